@@ design/assert_macros.svh @@
// Assertion macros shared by the hex record parser modules.
// No dependencies; each file that checks its own logic includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/hrp_pkg.sv @@
// Shared types and constants for the hex record parser.
// No dependencies; used by every module of the block.
package hrp_pkg;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;

  // End-of-record status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOCOL  = 3'd1;
  localparam logic [2:0] ST_BADHEX = 3'd2;
  localparam logic [2:0] ST_LEN    = 3'd3;
  localparam logic [2:0] ST_CSUM   = 3'd4;

  // Result kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // One classified character as it travels from the front to the back end.
  typedef struct packed {
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] nib;
  } ch_class_t;

endpackage

@@ design/hrp_classify.sv @@
// Front end: decodes one ASCII character into its class and hex nibble value.
// Depends on hrp_pkg for the character constants and the ch_class_t type.
module hrp_classify (
  input  logic [7:0]         ch,
  output hrp_pkg::ch_class_t cls
);

  logic is_digit;
  logic is_upper;
  logic is_lower;

  // Range checks for the three kinds of hex digit.
  assign is_digit = (ch >= hrp_pkg::CHAR_0)  && (ch <= hrp_pkg::CHAR_9);
  assign is_upper = (ch >= hrp_pkg::CHAR_UA) && (ch <= hrp_pkg::CHAR_UF);
  assign is_lower = (ch >= hrp_pkg::CHAR_LA) && (ch <= hrp_pkg::CHAR_LF_HEX);

  // Letters map A..F to 10..15 from their low four bits plus nine.
  always_comb begin
    cls.is_cr    = (ch == hrp_pkg::CHAR_CR);
    cls.is_lf    = (ch == hrp_pkg::CHAR_LF);
    cls.is_colon = (ch == hrp_pkg::CHAR_COLON);
    cls.is_hex   = is_digit || is_upper || is_lower;
    cls.nib      = is_digit ? ch[3:0] : (ch[3:0] + 4'd9);
  end

endmodule

@@ design/hrp_queue.sv @@
// Small first-in first-out queue of classified characters between the two ends.
// Depends on hrp_pkg for ch_class_t and on assert_macros.svh for its checks.
`include "assert_macros.svh"

module hrp_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hrp_pkg::ch_class_t push_data,
  output logic               full,
  input  logic               pop,
  output hrp_pkg::ch_class_t pop_data,
  output logic               not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  hrp_pkg::ch_class_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : (wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : (rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage writes need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // The occupancy never passes the depth, and a full queue stays full while nothing is popped.
  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `ASSERT_NEXT(a_full_holds, clk, rst_n, full && !pop, full)

endmodule

@@ design/hrp_engine.sv @@
// Back end: record state machine, checksum, address tracking and output register.
// Depends on hrp_pkg for ch_class_t and codes, and on assert_macros.svh.
`include "assert_macros.svh"

module hrp_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  hrp_pkg::ch_class_t item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [15:0]        out_address,
  output logic [7:0]         out_data_byte,
  output logic [7:0]         out_record_type,
  output logic [7:0]         out_byte_count,
  output logic [2:0]         out_status
);

  // Record phases.
  localparam logic [2:0] PH_COLON = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CSUM  = 3'd5;
  localparam logic [2:0] PH_TRAIL = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  hi_nib_r, hi_nib_nxt;
  logic        pending_r, pending_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] start_r, start_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r;
  logic [15:0] out_address_r;
  logic [7:0]  out_data_byte_r;
  logic [7:0]  out_record_type_r;
  logic [7:0]  out_byte_count_r;
  logic [2:0]  out_status_r;

  logic        emit;
  logic        emit_kind;
  logic [15:0] emit_address;
  logic [7:0]  emit_data;
  logic [2:0]  emit_status;
  logic [7:0]  byte_val;
  logic [7:0]  idx_inc;

  // An item moves on whenever the output register is free or being drained.
  assign item_take = item_valid && (!out_valid_r || out_ready);
  assign byte_val  = {hi_nib_r, item.nib};
  assign idx_inc   = idx_r + 8'd1;

  // Record parsing for the item taken this cycle.
  always_comb begin
    phase_nxt    = phase_r;
    hi_nib_nxt   = hi_nib_r;
    pending_nxt  = pending_r;
    count_nxt    = count_r;
    start_nxt    = start_r;
    type_nxt     = type_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    err_nxt      = err_r;
    emit         = 1'b0;
    emit_kind    = hrp_pkg::KIND_DATA;
    emit_address = start_r;
    emit_data    = 8'd0;
    emit_status  = hrp_pkg::ST_OK;
    if (item_take && !item.is_cr) begin
      if (item.is_lf) begin
        // Line end: report the status, then return to the idle state.
        emit      = 1'b1;
        emit_kind = hrp_pkg::KIND_END;
        if (err_r != hrp_pkg::ST_OK) begin
          emit_status = err_r;
        end else if (phase_r == PH_COLON) begin
          emit_status = hrp_pkg::ST_NOCOL;
        end else if ((phase_r != PH_TRAIL) || pending_r) begin
          emit_status = hrp_pkg::ST_LEN;
        end else if (sum_r != 8'd0) begin
          emit_status = hrp_pkg::ST_CSUM;
        end
        phase_nxt   = PH_COLON;
        hi_nib_nxt  = 4'd0;
        pending_nxt = 1'b0;
        count_nxt   = 8'd0;
        start_nxt   = 16'd0;
        type_nxt    = 8'd0;
        idx_nxt     = 8'd0;
        sum_nxt     = 8'd0;
        err_nxt     = hrp_pkg::ST_OK;
      end else if (err_r != hrp_pkg::ST_OK) begin
        // After the first error the rest of the line is skipped.
      end else if (phase_r == PH_COLON) begin
        if (item.is_colon) begin
          phase_nxt   = PH_COUNT;
          pending_nxt = 1'b0;
          sum_nxt     = 8'd0;
          idx_nxt     = 8'd0;
        end else begin
          err_nxt = hrp_pkg::ST_NOCOL;
        end
      end else if (phase_r == PH_TRAIL) begin
        err_nxt = hrp_pkg::ST_LEN;
      end else if (!item.is_hex) begin
        err_nxt = hrp_pkg::ST_BADHEX;
      end else if (!pending_r) begin
        hi_nib_nxt  = item.nib;
        pending_nxt = 1'b1;
      end else begin
        // A full byte is complete.
        pending_nxt = 1'b0;
        sum_nxt     = sum_r + byte_val;
        case (phase_r)
          PH_COUNT: begin
            count_nxt = byte_val;
            idx_nxt   = 8'd0;
            phase_nxt = PH_ADDR;
          end
          PH_ADDR: begin
            start_nxt = {start_r[7:0], byte_val};
            if (idx_inc >= 8'd2) begin
              idx_nxt   = 8'd0;
              phase_nxt = PH_TYPE;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          PH_TYPE: begin
            type_nxt  = byte_val;
            phase_nxt = (count_r == 8'd0) ? PH_CSUM : PH_DATA;
          end
          PH_DATA: begin
            emit         = 1'b1;
            emit_address = start_r + {8'd0, idx_r};
            emit_data    = byte_val;
            idx_nxt      = idx_inc;
            if (idx_inc >= count_r) begin
              phase_nxt = PH_CSUM;
            end
          end
          default: begin
            phase_nxt = PH_TRAIL;
          end
        endcase
      end
    end
  end

  // Output register: loads on a new result, clears when its transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COLON;
      hi_nib_r    <= 4'd0;
      pending_r   <= 1'b0;
      count_r     <= 8'd0;
      start_r     <= 16'd0;
      type_r      <= 8'd0;
      idx_r       <= 8'd0;
      sum_r       <= 8'd0;
      err_r       <= hrp_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hi_nib_r    <= hi_nib_nxt;
      pending_r   <= pending_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      type_r      <= type_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; type and count are captured before a line end clears them.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r        <= emit_kind;
      out_address_r     <= emit_address;
      out_data_byte_r   <= emit_data;
      out_record_type_r <= type_r;
      out_byte_count_r  <= count_r;
      out_status_r      <= emit_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_address     = out_address_r;
  assign out_data_byte   = out_data_byte_r;
  assign out_record_type = out_record_type_r;
  assign out_byte_count  = out_byte_count_r;
  assign out_status      = out_status_r;

  // A data result always carries an ok status.
  `ASSERT_IMPLIES(a_data_ok, clk, rst_n, out_valid_r && (out_kind_r == hrp_pkg::KIND_DATA), out_status_r == hrp_pkg::ST_OK)
  // A half byte is only pending inside the hex part of a record.
  `ASSERT_IMPLIES(a_pending_phase, clk, rst_n, pending_r, (phase_r != PH_COLON) && (phase_r != PH_TRAIL))
  // While data bytes remain, the index stays below the declared count.
  `ASSERT_IMPLIES(a_data_index, clk, rst_n, phase_r == PH_DATA, idx_r < count_r)
  // An item is never taken while an untaken result would be overwritten.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, item_take, !out_valid_r || out_ready)

endmodule

@@ design/hex_record_parser.sv @@
// Top level of the hex record parser: classifier, character queue and record engine.
// Depends on hrp_pkg, hrp_classify, hrp_queue and hrp_engine.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_ready  | in_ch (8 bits, one ASCII character)
//  out_    | output    | out_valid / out_ready| kind, address, data_byte, record_type,
//          |           |                      | byte_count, status
//
// One character is taken per cycle while the queue is not full; a character is written
// into the queue, then the engine loads its result into the output register.
// The engine advances one queued character per cycle while the output register is free
// or draining, so the rate is one character per cycle without output stalls.
// Output stalls back up into the QUEUE_DEPTH-entry queue before in_ready drops.
// Reset is synchronous on rst_n; the queue empties and the parser waits for a colon.
module hex_record_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_byte_count,
  output logic [2:0]  out_status
);

  hrp_pkg::ch_class_t in_cls;
  hrp_pkg::ch_class_t q_item;
  logic               q_full;
  logic               q_valid;
  logic               q_take;

  // Front end: classify the incoming character.
  hrp_classify u_classify (
    .ch  (in_ch),
    .cls (in_cls)
  );

  assign in_ready = !q_full;

  // Queue between the front end and the record engine.
  hrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (in_cls),
    .full      (q_full),
    .pop       (q_take),
    .pop_data  (q_item),
    .not_empty (q_valid)
  );

  // Back end: record parsing and result output.
  hrp_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (q_valid),
    .item            (q_item),
    .item_take       (q_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_address     (out_address),
    .out_data_byte   (out_data_byte),
    .out_record_type (out_record_type),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status)
  );

endmodule

@@ verif/hex_record_parser_tb.sv @@
// Self-checking testbench for hex_record_parser: ASCII records in, decoded bytes and status out.
// Depends on hrp_pkg and the hex_record_parser RTL; a built-in record decoder predicts results.
`timescale 1ns / 1ps

module hex_record_parser_tb;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int CHARS_PER_PHASE = 340;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int REPORT_LIMIT    = 10;

  // Where the decoder stands within one record.
  localparam logic [2:0] PH_WAIT_COLON = 3'd0;
  localparam logic [2:0] PH_COUNT      = 3'd1;
  localparam logic [2:0] PH_ADDR       = 3'd2;
  localparam logic [2:0] PH_TYPE       = 3'd3;
  localparam logic [2:0] PH_DATA       = 3'd4;
  localparam logic [2:0] PH_CSUM       = 3'd5;
  localparam logic [2:0] PH_TRAILER    = 3'd6;

  // One result as it leaves the block.
  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic [2:0]  status;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [15:0] out_address;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_record_type;
  logic [7:0]  out_byte_count;
  logic [2:0]  out_status;

  // Characters waiting to be offered, and results the decoder says must come.
  logic [7:0] char_stream[$];
  decoded_t   decoded_queue[$];
  logic [7:0] line_chars[$];
  logic [7:0] line_sum;
  int unsigned chars_queued = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        receiver_hold = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // Decoder state for the record in progress.
  logic [2:0]  rec_phase = PH_WAIT_COLON;
  logic [3:0]  rec_high_nib = 4'h0;
  logic        rec_nib_pending = 1'b0;
  logic [7:0]  rec_count = 8'h00;
  logic [15:0] rec_start = 16'h0000;
  logic [7:0]  rec_type = 8'h00;
  logic [7:0]  rec_index = 8'h00;
  logic [7:0]  rec_sum = 8'h00;
  logic [2:0]  rec_err = hrp_pkg::ST_OK;

  hex_record_parser uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_address     (out_address),
    .out_data_byte   (out_data_byte),
    .out_record_type (out_record_type),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status)
  );

  always #CLK_HALF clk = ~clk;

  // Returns {valid, nibble} for an ASCII character.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= hrp_pkg::CHAR_0 && c <= hrp_pkg::CHAR_9)
      return {1'b1, 4'(c - hrp_pkg::CHAR_0)};
    if (c >= hrp_pkg::CHAR_UA && c <= hrp_pkg::CHAR_UF)
      return {1'b1, 4'(c - hrp_pkg::CHAR_UA + 8'd10)};
    if (c >= hrp_pkg::CHAR_LA && c <= hrp_pkg::CHAR_LF_HEX)
      return {1'b1, 4'(c - hrp_pkg::CHAR_LA + 8'd10)};
    return 5'b0_0000;
  endfunction

  task automatic clear_record();
    rec_phase = PH_WAIT_COLON;
    rec_high_nib = 4'h0;
    rec_nib_pending = 1'b0;
    rec_count = 8'h00;
    rec_start = 16'h0000;
    rec_type = 8'h00;
    rec_index = 8'h00;
    rec_sum = 8'h00;
    rec_err = hrp_pkg::ST_OK;
  endtask

  task automatic push_decoded(input logic kind, input logic [15:0] addr,
                              input logic [7:0] dbyte, input logic [2:0] st);
    decoded_t r;
    r.kind = kind;
    r.address = addr;
    r.data_byte = dbyte;
    r.record_type = rec_type;
    r.byte_count = rec_count;
    r.status = st;
    decoded_queue.push_back(r);
  endtask

  // Advances the record decoder by one transferred character.
  task automatic decode_char(input logic [7:0] c);
    logic [4:0] dig;
    logic [7:0] b;
    logic [2:0] st;
    if (c == hrp_pkg::CHAR_CR) return;
    if (c == hrp_pkg::CHAR_LF) begin
      if (rec_err != hrp_pkg::ST_OK) st = rec_err;
      else if (rec_phase == PH_WAIT_COLON) st = hrp_pkg::ST_NOCOL;
      else if (rec_phase != PH_TRAILER || rec_nib_pending) st = hrp_pkg::ST_LEN;
      else if (rec_sum != 8'h00) st = hrp_pkg::ST_CSUM;
      else st = hrp_pkg::ST_OK;
      push_decoded(hrp_pkg::KIND_END, rec_start, 8'h00, st);
      clear_record();
      return;
    end
    if (rec_err != hrp_pkg::ST_OK) return;
    if (rec_phase == PH_WAIT_COLON) begin
      if (c == hrp_pkg::CHAR_COLON) begin
        rec_phase = PH_COUNT;
        rec_nib_pending = 1'b0;
        rec_sum = 8'h00;
        rec_index = 8'h00;
      end else begin
        rec_err = hrp_pkg::ST_NOCOL;
      end
      return;
    end
    if (rec_phase == PH_TRAILER) begin
      rec_err = hrp_pkg::ST_LEN;
      return;
    end
    dig = digit_value(c);
    if (!dig[4]) begin
      rec_err = hrp_pkg::ST_BADHEX;
      return;
    end
    if (!rec_nib_pending) begin
      rec_high_nib = dig[3:0];
      rec_nib_pending = 1'b1;
      return;
    end
    rec_nib_pending = 1'b0;
    b = {rec_high_nib, dig[3:0]};
    rec_sum = rec_sum + b;
    case (rec_phase)
      PH_COUNT: begin
        rec_count = b;
        rec_index = 8'h00;
        rec_phase = PH_ADDR;
      end
      PH_ADDR: begin
        rec_start = {rec_start[7:0], b};
        rec_index = rec_index + 8'd1;
        if (rec_index >= 8'd2) begin
          rec_index = 8'h00;
          rec_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        rec_type = b;
        rec_phase = (rec_count == 8'h00) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        push_decoded(hrp_pkg::KIND_DATA, rec_start + {8'h00, rec_index}, b,
                     hrp_pkg::ST_OK);
        rec_index = rec_index + 8'd1;
        if (rec_index >= rec_count) rec_phase = PH_CSUM;
      end
      default: begin
        rec_phase = PH_TRAILER;
      end
    endcase
  endtask

  // Hex digit in a random case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return hrp_pkg::CHAR_0 + {4'h0, nib};
    return ($urandom_range(1) ? hrp_pkg::CHAR_UA : hrp_pkg::CHAR_LA) + {4'h0, nib} - 8'd10;
  endfunction

  // Any character except the line terminators.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == hrp_pkg::CHAR_CR || c == hrp_pkg::CHAR_LF);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] dig;
    do begin
      c = plain_char();
      dig = digit_value(c);
    end while (dig[4]);
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    line_sum = line_sum + b;
    line_chars.push_back(hex_char(b[7:4]));
    line_chars.push_back(hex_char(b[3:0]));
  endtask

  // Builds a full record text; a nonzero flip corrupts the checksum.
  task automatic build_record(input int unsigned n, input logic [15:0] addr,
                              input logic [7:0] rtype, input logic [7:0] csum_flip);
    logic [7:0] nb;
    nb = n[7:0];
    line_chars.delete();
    line_chars.push_back(hrp_pkg::CHAR_COLON);
    line_sum = 8'h00;
    add_byte(nb);
    add_byte(addr[15:8]);
    add_byte(addr[7:0]);
    add_byte(rtype);
    repeat (n) add_byte(8'($urandom_range(255)));
    add_byte((8'h00 - line_sum) ^ csum_flip);
  endtask

  // Queues the current line, sometimes with a stray carriage return inside it.
  task automatic send_line(input bit with_cr);
    int unsigned pos;
    if (line_chars.size() > 0 && $urandom_range(9) == 0) begin
      pos = $urandom_range(line_chars.size() - 1);
      line_chars.insert(pos, hrp_pkg::CHAR_CR);
    end
    foreach (line_chars[i]) begin
      char_stream.push_back(line_chars[i]);
      if (line_chars[i] != hrp_pkg::CHAR_CR) chars_queued++;
    end
    if (with_cr) char_stream.push_back(hrp_pkg::CHAR_CR);
    char_stream.push_back(hrp_pkg::CHAR_LF);
    chars_queued++;
  endtask

  // Mostly well-formed records, the rest broken in each way the parser reports.
  task automatic queue_random_line();
    int unsigned mode;
    int unsigned n;
    int unsigned keep;
    logic [15:0] addr;
    logic [7:0]  rtype;
    logic [7:0]  flip;
    logic [7:0]  c;
    mode = $urandom_range(99);
    n = ($urandom_range(49) == 0) ? $urandom_range(255) : $urandom_range(16);
    addr = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(15))
                                     : 16'($urandom_range(16'hFFFF));
    rtype = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
    flip = (mode >= 70 && mode < 76) ? 8'($urandom_range(1, 255)) : 8'h00;
    build_record(n, addr, rtype, flip);
    if (mode >= 76 && mode < 82) begin
      line_chars[$urandom_range(1, line_chars.size() - 1)] = non_hex_char();
    end else if (mode >= 82 && mode < 88) begin
      keep = $urandom_range(1, line_chars.size() - 1);
      while (line_chars.size() > keep) void'(line_chars.pop_back());
    end else if (mode >= 88 && mode < 91) begin
      repeat ($urandom_range(1, 3)) line_chars.push_back(plain_char());
    end else if (mode >= 91 && mode < 94) begin
      do c = plain_char(); while (c == hrp_pkg::CHAR_COLON);
      line_chars.push_front(c);
    end else if (mode >= 94 && mode < 96) begin
      line_chars.delete();
    end else if (mode >= 96) begin
      line_chars.delete();
      repeat ($urandom_range(1, 12)) line_chars.push_back(plain_char());
    end
    send_line(1'($urandom_range(1)));
  endtask

  // Short list of lines that hit each reported condition and the field extremes.
  task automatic queue_directed_lines();
    line_chars.delete();
    send_line(1'b0);
    build_record(0, 16'h0000, 8'h01, 8'h00);
    send_line(1'b1);
    build_record(2, 16'hFFFF, 8'h00, 8'h00);
    send_line(1'b0);
    build_record(1, 16'h8000, 8'hFF, 8'h00);
    send_line(1'b0);
    build_record(1, 16'h1234, 8'h00, 8'h00);
    line_chars.push_front(8'hFF);
    send_line(1'b0);
    build_record(1, 16'h1234, 8'h00, 8'h00);
    line_chars.push_front(8'h00);
    send_line(1'b0);
    build_record(3, 16'h0100, 8'h00, 8'h00);
    line_chars[11] = non_hex_char();
    send_line(1'b0);
    build_record(1, 16'h0200, 8'h00, 8'h00);
    line_chars[5] = hrp_pkg::CHAR_COLON;
    send_line(1'b0);
    line_chars.delete();
    line_chars.push_back(hrp_pkg::CHAR_COLON);
    line_chars.push_back(hrp_pkg::CHAR_0);
    send_line(1'b0);
    build_record(2, 16'h0300, 8'h00, 8'h00);
    while (line_chars.size() > 9) void'(line_chars.pop_back());
    send_line(1'b0);
    build_record(1, 16'h0400, 8'h00, 8'h00);
    line_chars.push_back(hrp_pkg::CHAR_0);
    send_line(1'b0);
    build_record(1, 16'h0500, 8'h02, 8'h01);
    send_line(1'b0);
    build_record(255, 16'hFFF0, 8'h04, 8'h00);
    send_line(1'b1);
  endtask

  // Returns once the stream is empty and every predicted result has arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (char_stream.size() != 0 || in_valid || decoded_queue.size() != 0);
  endtask

  // Driver: offers queued characters and feeds each transfer to the decoder.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch <= 8'h00;
    end else begin
      if (in_valid && in_ready) decode_char(in_ch);
      if (!in_valid || in_ready) begin
        if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_ch <= char_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result transfer with the oldest prediction.
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_kind, out_address, out_data_byte, out_record_type,
               out_byte_count, out_status};
        if (decoded_queue.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: result with nothing predicted", $realtime);
            $display("  got:  kind=%0d addr=%h data=%h type=%h count=%h status=%0d",
                     got.kind, got.address, got.data_byte, got.record_type,
                     got.byte_count, got.status);
          end
          mismatch_count++;
        end else begin
          want = decoded_queue.pop_front();
          if (got !== want) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  got:  kind=%0d addr=%h data=%h type=%h count=%h status=%0d",
                       got.kind, got.address, got.data_byte, got.record_type,
                       got.byte_count, got.status);
              $display("  want: kind=%0d addr=%h data=%h type=%h count=%h status=%0d",
                       want.kind, want.address, want.data_byte, want.record_type,
                       want.byte_count, want.status);
            end
            mismatch_count++;
          end
        end
      end
      out_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Length of the current receiver hold-off.
  always @(posedge clk) begin
    hold_cycles <= receiver_hold ? hold_cycles + 1 : 0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hex_record_parser test failed");
      $finish;
    end
  end

  // Stimulus sequence: directed lines, then random lines under each idling mix.
  initial begin
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    int unsigned phase_start;
    send_pct = '{0, 55, 0, 31};
    recv_pct = '{0, 0, 55, 31};
    clear_record();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0) queue_directed_lines();
      phase_start = chars_queued;
      while (chars_queued - phase_start < CHARS_PER_PHASE) queue_random_line();
      // Stall the receiver long enough to back the block up into its input.
      if (p == 0) begin
        receiver_hold = 1'b1;
        while (hold_cycles < HOLD_CYCLES) @(negedge clk);
        receiver_hold = 1'b0;
      end
      wait_drained();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && decoded_queue.size() == 0) begin
      $display("hex_record_parser test passed");
    end else begin
      $display("hex_record_parser test failed");
    end
    $finish;
  end

endmodule
